>>> design/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU page replacement core: the control
// bits of the search token, the update command and the sequencer states.
// ----------------------------------------------------------------------------
package lfu_pkg;

  // fixed port widths
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned PORT_PAGE_W = 16;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned FAULT_W     = 16;

  localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
  localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

  // control bits carried by the search token from cell to cell
  typedef struct packed {
    logic pulse;       // token present in this link
    logic found;       // a resident copy was matched upstream
    logic have_best;   // a victim candidate has been picked upstream
    logic best_valid;  // the candidate frame is occupied
  } sch_ctl_t;

  // update command broadcast to all cells
  typedef struct packed {
    logic apply;       // commit the reference this cycle
    logic hit;         // reference was a hit
  } upd_ctl_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

endpackage

>>> design/lfu_cell.sv
// ----------------------------------------------------------------------------
// lfu_cell
// One page frame: holds valid, page, use count and age. Folds its own frame
// into the search token as it passes and registers the token for the next
// cell; applies the broadcast update on the commit cycle.
// ----------------------------------------------------------------------------
module lfu_cell
  import lfu_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int IW         = 3,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  active,
  input  logic [PAGE_BITS-1:0]  ref_page,
  input  upd_ctl_t              upd,
  input  logic [IW-1:0]         upd_slot,
  input  sch_ctl_t              ctl_in,
  input  logic [IW-1:0]         hit_idx_in,
  input  logic [IW-1:0]         best_idx_in,
  input  logic [COUNT_BITS-1:0] best_uses_in,
  input  logic [COUNT_BITS-1:0] best_age_in,
  input  logic [PAGE_BITS-1:0]  best_page_in,
  output sch_ctl_t              ctl_out,
  output logic [IW-1:0]         hit_idx_out,
  output logic [IW-1:0]         best_idx_out,
  output logic [COUNT_BITS-1:0] best_uses_out,
  output logic [COUNT_BITS-1:0] best_age_out,
  output logic [PAGE_BITS-1:0]  best_page_out
);

  localparam logic [IW-1:0]         OWN       = IW'(IDX);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // frame state
  logic                  valid;
  logic [PAGE_BITS-1:0]  page;
  logic [COUNT_BITS-1:0] uses;
  logic [COUNT_BITS-1:0] age;

  logic     match;
  logic     better;
  logic     take_hit;
  logic     take_best;
  logic     sel;
  sch_ctl_t ctl_next;

  // compare this frame against the token
  always_comb begin
    match     = active && valid && (page == ref_page);
    take_hit  = !ctl_in.found && match;
    better    = (uses < best_uses_in) || ((uses == best_uses_in) && (age > best_age_in));
    take_best = active && (!ctl_in.have_best || better);
    ctl_next.pulse      = ctl_in.pulse;
    ctl_next.found      = ctl_in.found || match;
    ctl_next.have_best  = ctl_in.have_best || active;
    ctl_next.best_valid = take_best ? valid : ctl_in.best_valid;
  end

  // token register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (ctl_in.pulse) begin
      ctl_out <= ctl_next;
    end else begin
      ctl_out.pulse <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.pulse) begin
      hit_idx_out   <= take_hit ? OWN : hit_idx_in;
      best_idx_out  <= take_best ? OWN : best_idx_in;
      best_uses_out <= take_best ? uses : best_uses_in;
      best_age_out  <= take_best ? age : best_age_in;
      best_page_out <= take_best ? page : best_page_in;
    end
  end

  // commit: fill on fault, count on hit, age every active occupied frame
  assign sel = upd.apply && (upd_slot == OWN);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      uses  <= '0;
      age   <= '0;
    end else if (sel && !upd.hit) begin
      valid <= 1'b1;
      uses  <= COUNT_ONE;
      age   <= COUNT_ONE;
    end else if (upd.apply && active && valid) begin
      age <= (age == COUNT_MAX) ? age : age + COUNT_ONE;
      if (sel) begin
        uses <= (uses == COUNT_MAX) ? uses : uses + COUNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && !upd.hit) begin
      page <= ref_page;
    end
  end

endmodule

>>> design/lfu_page_replacement_core.sv
// ----------------------------------------------------------------------------
// lfu_page_replacement_core
// LFU page replacement with oldest-first tie break over a row of frame cells.
// ----------------------------------------------------------------------------
// One page reference is taken per item and answered with one result. The
// next reference waits until the item has passed the launch register, the
// register of each frame cell as the search token walks the chain of cells,
// pick-up of the token at the tail and the commit, which updates every frame
// and loads the output register. The commit waits while a previous result is
// still stalled in the output register. frames_in_use must be written by the
// user through the cfg channel only while the core is idle; the core does not
// enforce it. Zero acts as one, values above NUM_FRAMES act as NUM_FRAMES.
// ----------------------------------------------------------------------------
module lfu_page_replacement_core
  import lfu_pkg::*;
#(
  parameter int NUM_FRAMES = 8,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,
  // page references
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [PORT_PAGE_W-1:0] page_number,
  // results
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   hit,
  output logic [SLOT_W-1:0]      frame_slot,
  output logic                   evicted_valid,
  output logic [PORT_PAGE_W-1:0] evicted_page,
  output logic [FAULT_W-1:0]     fault_total
);

  localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int NW = $clog2(NUM_FRAMES + 1);

  state_t state, state_next;

  logic [CFG_W-1:0]      frames_in_use;
  logic [NW-1:0]         n_act;
  logic [NUM_FRAMES-1:0] active;
  logic [PAGE_BITS-1:0]  ref_page;
  logic                  launch;
  logic [FAULT_W-1:0]    fault_count;
  logic [FAULT_W-1:0]    fault_count_next;
  logic                  in_xfer;
  logic                  out_free;
  upd_ctl_t              upd;
  logic [IW-1:0]         upd_slot;
  logic                  ev_valid;

  // token links between cells
  sch_ctl_t              link_ctl  [NUM_FRAMES+1];
  logic [IW-1:0]         link_hit  [NUM_FRAMES+1];
  logic [IW-1:0]         link_idx  [NUM_FRAMES+1];
  logic [COUNT_BITS-1:0] link_uses [NUM_FRAMES+1];
  logic [COUNT_BITS-1:0] link_age  [NUM_FRAMES+1];
  logic [PAGE_BITS-1:0]  link_page [NUM_FRAMES+1];

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frames_in_use <= cfg_data;
    end
  end

  // clamp the active frame count
  always_comb begin
    if (frames_in_use == '0) begin
      n_act = NW'(1);
    end else if (32'(frames_in_use) > NUM_FRAMES) begin
      n_act = NW'(NUM_FRAMES);
    end else begin
      n_act = NW'(frames_in_use);
    end
  end

  // input transfer and launch of the search token
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ref_page <= PAGE_BITS'(page_number);
    end
  end

  // head of the chain
  always_comb begin
    link_ctl[0]       = '0;
    link_ctl[0].pulse = launch;
    link_hit[0]       = '0;
    link_idx[0]       = '0;
    link_uses[0]      = '0;
    link_age[0]       = '0;
    link_page[0]      = '0;
  end

  // row of frame cells
  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    assign active[i] = (32'(n_act) > i);

    lfu_cell #(
      .IDX        (i),
      .IW         (IW),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .active        (active[i]),
      .ref_page      (ref_page),
      .upd           (upd),
      .upd_slot      (upd_slot),
      .ctl_in        (link_ctl[i]),
      .hit_idx_in    (link_hit[i]),
      .best_idx_in   (link_idx[i]),
      .best_uses_in  (link_uses[i]),
      .best_age_in   (link_age[i]),
      .best_page_in  (link_page[i]),
      .ctl_out       (link_ctl[i+1]),
      .hit_idx_out   (link_hit[i+1]),
      .best_idx_out  (link_idx[i+1]),
      .best_uses_out (link_uses[i+1]),
      .best_age_out  (link_age[i+1]),
      .best_page_out (link_page[i+1])
    );
  end

  // commit command from the tail of the chain
  assign out_free  = !out_valid || !out_stall;
  assign upd.apply = (state == S_UPDATE) && out_free;
  assign upd.hit   = link_ctl[NUM_FRAMES].found;
  assign upd_slot  = upd.hit ? link_hit[NUM_FRAMES] : link_idx[NUM_FRAMES];
  assign ev_valid  = !upd.hit && link_ctl[NUM_FRAMES].best_valid;

  always_comb begin
    if (!upd.hit && (fault_count != FAULT_MAX)) begin
      fault_count_next = fault_count + FAULT_W'(1);
    end else begin
      fault_count_next = fault_count;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_xfer) state_next = S_SEARCH;
      S_SEARCH: if (link_ctl[NUM_FRAMES].pulse) state_next = S_UPDATE;
      S_UPDATE: if (upd.apply) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fault_count <= '0;
    end else begin
      state <= state_next;
      if (upd.apply) begin
        fault_count <= fault_count_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd.apply) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.apply) begin
      hit           <= upd.hit;
      frame_slot    <= SLOT_W'(upd_slot);
      evicted_valid <= ev_valid;
      evicted_page  <= ev_valid ? PORT_PAGE_W'(link_page[NUM_FRAMES]) : '0;
      fault_total   <= fault_count_next;
    end
  end

  // checks
  a_tail_in_search: assert property (@(posedge clk) disable iff (rst)
    link_ctl[NUM_FRAMES].pulse |-> (state == S_SEARCH))
    else $error("search token reached the tail outside the search phase");

  a_launch_in_search: assert property (@(posedge clk) disable iff (rst)
    launch |-> (state == S_SEARCH))
    else $error("search token launched outside the search phase");

  a_victim_found: assert property (@(posedge clk) disable iff (rst)
    (upd.apply && !upd.hit) |-> link_ctl[NUM_FRAMES].have_best)
    else $error("fault committed without a victim frame");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (!evicted_valid && (evicted_page == '0)))
    else $error("hit result reports an eviction");

  a_commit_one: assert property (@(posedge clk) disable iff (rst)
    upd.apply |=> (state == S_IDLE) && out_valid)
    else $error("commit did not produce a result");

endmodule
